@@ design/gpb_pkg.sv @@
// gpb_pkg: shared types and constants for the gpio pin register block
// register map offsets, pin function codes, decode and result structs
// no dependencies
`timescale 1ns / 1ps

package gpb_pkg;

   localparam int GPB_NUM_PINS = 54;

   localparam int WORD_W     = 32;
   localparam int PIN_WORDS  = 2;
   localparam int PIN_BITS   = PIN_WORDS * WORD_W;
   localparam int OUT_HIGH_W = 22;

   localparam int FSEL_WORDS    = 6;
   localparam int FSEL_W        = 3;
   localparam int FSEL_PER_WORD = 10;
   localparam int FSEL_PINS     = FSEL_WORDS * FSEL_PER_WORD;
   localparam int DET_WORDS     = 12;
   localparam int DET_GROUPS    = 6;
   localparam int DET_STRIDE    = 12;

   localparam logic [FSEL_W-1:0] FSEL_INPUT  = 3'h0;
   localparam logic [FSEL_W-1:0] FSEL_OUTPUT = 3'h1;

   localparam logic [7:0] OFF_FSEL_LAST = 8'h14;
   localparam logic [7:0] OFF_SET0      = 8'h1c;
   localparam logic [7:0] OFF_SET1      = 8'h20;
   localparam logic [7:0] OFF_CLR0      = 8'h28;
   localparam logic [7:0] OFF_CLR1      = 8'h2c;
   localparam logic [7:0] OFF_LEV0      = 8'h34;
   localparam logic [7:0] OFF_EDS0      = 8'h40;
   localparam logic [7:0] OFF_DET0      = 8'h4c;
   localparam logic [7:0] OFF_DET_LAST  = 8'h8c;
   localparam logic [7:0] OFF_PUD       = 8'h94;
   localparam logic [7:0] WORD_STEP     = 8'h04;

   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_EVENT = 2'd2,
      MODE_NONE  = 2'd3
   } gpb_mode_type;

   typedef enum logic [3:0] {
      TGT_NONE,
      TGT_FSEL,
      TGT_SET,
      TGT_CLR,
      TGT_LEV,
      TGT_EDS,
      TGT_DET,
      TGT_PUD,
      TGT_PUDCLK
   } gpb_target_type;

   typedef struct packed {
      gpb_target_type target;
      logic [3:0]     idx;
      logic           rd_ok;
      logic           wr_ok;
   } gpb_dec_type;

   typedef struct packed {
      logic [WORD_W-1:0]     read_data;
      logic                  bad_offset;
      logic [WORD_W-1:0]     out_low;
      logic [OUT_HIGH_W-1:0] out_high;
   } gpb_result_type;

endpackage

@@ design/gpb_decode.sv @@
// gpb_decode: byte offset to register target, word index and access rights
// depends on gpb_pkg
`timescale 1ns / 1ps

module gpb_decode
   import gpb_pkg::*;
(
   input  logic [7:0]  offset,
   output gpb_dec_type dec
);

   logic       det_hit;
   logic [3:0] det_idx;

   always_comb begin
      det_hit = 1'b0;
      det_idx = 4'd0;
      for (int g = 0; g < DET_GROUPS; g++) begin
         if (offset == OFF_DET0 + 8'(DET_STRIDE * g)) begin
            det_hit = 1'b1;
            det_idx = 4'(2 * g);
         end
         if (offset == OFF_DET0 + 8'(DET_STRIDE * g) + WORD_STEP) begin
            det_hit = 1'b1;
            det_idx = 4'(2 * g + 1);
         end
      end
   end

   always_comb begin
      dec.target = TGT_NONE;
      dec.idx    = 4'd0;
      dec.rd_ok  = 1'b0;
      dec.wr_ok  = 1'b0;
      if (offset[1:0] == 2'b00) begin
         priority if (offset <= OFF_FSEL_LAST) begin
            dec.target = TGT_FSEL;
            dec.idx    = offset[5:2];
            dec.rd_ok  = 1'b1;
            dec.wr_ok  = 1'b1;
         end else if (offset == OFF_SET0 || offset == OFF_SET1) begin
            dec.target = TGT_SET;
            dec.idx    = {3'd0, offset == OFF_SET1};
            dec.wr_ok  = 1'b1;
         end else if (offset == OFF_CLR0 || offset == OFF_CLR1) begin
            dec.target = TGT_CLR;
            dec.idx    = {3'd0, offset == OFF_CLR1};
            dec.wr_ok  = 1'b1;
         end else if (offset == OFF_LEV0 || offset == OFF_LEV0 + WORD_STEP) begin
            dec.target = TGT_LEV;
            dec.idx    = {3'd0, offset != OFF_LEV0};
            dec.rd_ok  = 1'b1;
         end else if (offset == OFF_EDS0 || offset == OFF_EDS0 + WORD_STEP) begin
            dec.target = TGT_EDS;
            dec.idx    = {3'd0, offset != OFF_EDS0};
            dec.rd_ok  = 1'b1;
            dec.wr_ok  = 1'b1;
         end else if (offset >= OFF_DET0 && offset <= OFF_DET_LAST) begin
            if (det_hit) begin
               dec.target = TGT_DET;
               dec.idx    = det_idx;
               dec.rd_ok  = 1'b1;
               dec.wr_ok  = 1'b1;
            end
         end else if (offset == OFF_PUD) begin
            dec.target = TGT_PUD;
            dec.rd_ok  = 1'b1;
            dec.wr_ok  = 1'b1;
         end else if (offset == OFF_PUD + WORD_STEP
                      || offset == OFF_PUD + WORD_STEP + WORD_STEP) begin
            dec.target = TGT_PUDCLK;
            dec.idx    = {3'd0, offset != OFF_PUD + WORD_STEP};
            dec.rd_ok  = 1'b1;
            dec.wr_ok  = 1'b1;
         end else begin
            dec.target = TGT_NONE;
         end
      end
   end

endmodule

@@ design/gpb_core.sv @@
// gpb_core: register storage, read mux, set/clear pass and pin level update
// depends on gpb_pkg and gpb_decode
`timescale 1ns / 1ps

module gpb_core
   import gpb_pkg::*;
#(
   parameter int NUM_PINS = GPB_NUM_PINS
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  gpb_mode_type      mode,
   input  logic [7:0]        offset,
   input  logic [WORD_W-1:0] write_data,
   input  logic [5:0]        pin,
   input  logic              level,
   output gpb_result_type    result
);

   logic [FSEL_WORDS-1:0][WORD_W-1:0] fsel_ff, fsel_w, fsel_in;
   logic [PIN_WORDS-1:0][WORD_W-1:0]  set_ff, set_w, set_in;
   logic [PIN_WORDS-1:0][WORD_W-1:0]  clr_ff, clr_w, clr_in;
   logic [PIN_WORDS-1:0][WORD_W-1:0]  out_ff, out_in;
   logic [PIN_WORDS-1:0][WORD_W-1:0]  lev_ff, lev_in;
   logic [PIN_WORDS-1:0][WORD_W-1:0]  eds_ff, eds_in;
   logic [DET_WORDS-1:0][WORD_W-1:0]  det_ff, det_in;
   logic [WORD_W-1:0]                 pud_ff, pud_in;
   logic [PIN_WORDS-1:0][WORD_W-1:0]  pudclk_ff, pudclk_in;

   gpb_dec_type         dec;
   logic                good_rd;
   logic                good_wr;
   logic [WORD_W-1:0]   rd_mux;
   logic [PIN_BITS-1:0] out_en;
   logic [PIN_BITS-1:0] out_cur;
   logic [PIN_BITS-1:0] is_in;
   logic [PIN_BITS-1:0] hit_set;
   logic [PIN_BITS-1:0] hit_clr;
   logic [PIN_BITS-1:0] lev_flat;
   logic                pin_ok;

   gpb_decode u_decode (
      .offset (offset),
      .dec    (dec)
   );

   assign good_rd = (mode == MODE_READ) && dec.rd_ok;
   assign good_wr = (mode == MODE_WRITE) && dec.wr_ok;
   assign pin_ok  = {1'b0, pin} < 7'(NUM_PINS);

   always_comb begin
      unique case (dec.target)
         TGT_FSEL:   rd_mux = fsel_ff[dec.idx[2:0]];
         TGT_LEV:    rd_mux = lev_ff[dec.idx[0]];
         TGT_EDS:    rd_mux = eds_ff[dec.idx[0]];
         TGT_DET:    rd_mux = det_ff[dec.idx];
         TGT_PUD:    rd_mux = pud_ff;
         TGT_PUDCLK: rd_mux = pudclk_ff[dec.idx[0]];
         default:    rd_mux = '0;
      endcase
   end

   // storage after the bus write, before the set/clear pass
   always_comb begin
      fsel_w    = fsel_ff;
      set_w     = set_ff;
      clr_w     = clr_ff;
      eds_in    = eds_ff;
      det_in    = det_ff;
      pud_in    = pud_ff;
      pudclk_in = pudclk_ff;
      if (good_wr) begin
         unique case (dec.target)
            TGT_FSEL:   fsel_w[dec.idx[2:0]]    = write_data;
            TGT_SET:    set_w[dec.idx[0]]       = write_data;
            TGT_CLR:    clr_w[dec.idx[0]]       = write_data;
            TGT_EDS:    eds_in[dec.idx[0]]      = write_data;
            TGT_DET:    det_in[dec.idx]         = write_data;
            TGT_PUD:    pud_in                  = write_data;
            TGT_PUDCLK: pudclk_in[dec.idx[0]]   = write_data;
            default:    ;
         endcase
      end
   end

   for (genvar p = 0; p < PIN_BITS; p++) begin : g_pin
      if (p < FSEL_PINS) begin : g_sel
         assign out_en[p]  = (p < NUM_PINS) ?
            (fsel_w[p / FSEL_PER_WORD][FSEL_W * (p % FSEL_PER_WORD) +: FSEL_W]
             == FSEL_OUTPUT) : 1'b0;
         assign out_cur[p] = (p < NUM_PINS) ?
            (fsel_ff[p / FSEL_PER_WORD][FSEL_W * (p % FSEL_PER_WORD) +: FSEL_W]
             == FSEL_OUTPUT) : 1'b0;
         assign is_in[p]   =
            fsel_ff[p / FSEL_PER_WORD][FSEL_W * (p % FSEL_PER_WORD) +: FSEL_W]
            == FSEL_INPUT;
      end else begin : g_nosel
         assign out_en[p]  = 1'b0;
         assign out_cur[p] = 1'b0;
         assign is_in[p]   = 1'b1;
      end
   end

   // set wins over clear
   assign hit_set = out_en & set_w & {PIN_BITS{good_wr}};
   assign hit_clr = out_en & ~set_w & clr_w & {PIN_BITS{good_wr}};

   assign fsel_in = fsel_w;
   assign set_in  = set_w & ~hit_set;
   assign clr_in  = clr_w & ~hit_clr;
   assign out_in  = (out_ff | hit_set) & ~hit_clr;

   always_comb begin
      lev_flat = lev_ff;
      if (mode == MODE_EVENT && pin_ok && is_in[pin]) begin
         lev_flat[pin] = level;
      end
      lev_in = lev_flat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsel_ff   <= '0;
         set_ff    <= '0;
         clr_ff    <= '0;
         out_ff    <= '0;
         lev_ff    <= '0;
         eds_ff    <= '0;
         det_ff    <= '0;
         pud_ff    <= '0;
         pudclk_ff <= '0;
      end else if (fire) begin
         fsel_ff   <= fsel_in;
         set_ff    <= set_in;
         clr_ff    <= clr_in;
         out_ff    <= out_in;
         lev_ff    <= lev_in;
         eds_ff    <= eds_in;
         det_ff    <= det_in;
         pud_ff    <= pud_in;
         pudclk_ff <= pudclk_in;
      end
   end

   assign result.read_data  = good_rd ? rd_mux : '0;
   assign result.bad_offset = (mode == MODE_READ && !dec.rd_ok)
                              || (mode == MODE_WRITE && !dec.wr_ok);
   assign result.out_low    = out_in[0];
   assign result.out_high   = out_in[1][OUT_HIGH_W-1:0];

`ifndef ASSERT_OFF
   a_no_write_keeps_out: assert property (@(posedge clock) disable iff (reset)
      fire && mode != MODE_WRITE |=> $stable(out_ff))
      else $error("output state changed without a write");

   a_set_pass_done: assert property (@(posedge clock) disable iff (reset)
      fire && good_wr |=> (set_ff & out_cur) == '0)
      else $error("set bit left pending on an output pin");

   a_read_keeps_state: assert property (@(posedge clock) disable iff (reset)
      fire && mode == MODE_READ |=> $stable(fsel_ff) && $stable(set_ff) && $stable(clr_ff))
      else $error("read changed storage");
`endif

endmodule

@@ design/gpio_pin_register_block.sv @@
// gpio_pin_register_block: an accepted item passes the input register, then
// the result register; one item per cycle while the result is not stalled
// a stalled result holds while one more item waits in the input register
// reset is synchronous, active high, clears core storage and handshake state
// no clearing pass after reset; the first item may be accepted right after it
// depends on gpb_pkg and gpb_core
`timescale 1ns / 1ps

module gpio_pin_register_block
   import gpb_pkg::*;
#(
   parameter int NUM_PINS = GPB_NUM_PINS
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [7:0]            req_offset,
   input  logic [WORD_W-1:0]     req_write_data,
   input  logic [5:0]            req_pin,
   input  logic                  req_level,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [WORD_W-1:0]     rsp_read_data,
   output logic                  rsp_bad_offset,
   output logic [WORD_W-1:0]     rsp_out_pins_low,
   output logic [OUT_HIGH_W-1:0] rsp_out_pins_high
);

   logic              in_vld_ff, in_vld_in;
   logic [1:0]        mode_ff;
   logic [7:0]        offset_ff;
   logic [WORD_W-1:0] wdata_ff;
   logic [5:0]        pin_ff;
   logic              level_ff;
   logic              rsp_vld_ff, rsp_vld_in;
   gpb_result_type    result_ff;
   gpb_result_type    result_in;
   logic              accept;
   logic              advance;

   assign advance   = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept || (in_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && rsp_stall);

   gpb_core #(
      .NUM_PINS (NUM_PINS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .mode       (gpb_mode_type'(mode_ff)),
      .offset     (offset_ff),
      .write_data (wdata_ff),
      .pin        (pin_ff),
      .level      (level_ff),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_mode;
         offset_ff <= req_offset;
         wdata_ff  <= req_write_data;
         pin_ff    <= req_pin;
         level_ff  <= req_level;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_read_data     = result_ff.read_data;
   assign rsp_bad_offset    = result_ff.bad_offset;
   assign rsp_out_pins_low  = result_ff.out_low;
   assign rsp_out_pins_high = result_ff.out_high;

`ifndef ASSERT_OFF
   a_bad_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && result_ff.bad_offset |-> result_ff.read_data == '0)
      else $error("error item carries read data");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && rsp_vld_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

   a_stalled_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_stall |=> rsp_vld_ff && $stable(result_ff))
      else $error("stalled result item changed");
`endif

endmodule

@@ verif/gpb_checker.sv @@
// gpb_checker: watches both channels of the gpio pin register block, predicts each
// result from its own copy of the register state and compares field by field
// depends on gpb_pkg
`timescale 1ns / 1ps

module gpb_checker
   import gpb_pkg::*;
#(
   parameter int NUM_PINS = GPB_NUM_PINS
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [7:0]            req_offset,
   input  logic [WORD_W-1:0]     req_write_data,
   input  logic [5:0]            req_pin,
   input  logic                  req_level,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [WORD_W-1:0]     rsp_read_data,
   input  logic                  rsp_bad_offset,
   input  logic [WORD_W-1:0]     rsp_out_pins_low,
   input  logic [OUT_HIGH_W-1:0] rsp_out_pins_high,
   output int                    fail_count,
   output int                    waiting,
   output int                    checked,
   output int                    flagged
);

   logic [WORD_W-1:0] fsel_q   [FSEL_WORDS];
   logic [WORD_W-1:0] set_q    [PIN_WORDS];
   logic [WORD_W-1:0] clr_q    [PIN_WORDS];
   logic [WORD_W-1:0] drive_q  [PIN_WORDS];
   logic [WORD_W-1:0] level_q  [PIN_WORDS];
   logic [WORD_W-1:0] status_q [PIN_WORDS];
   logic [WORD_W-1:0] detect_q [DET_WORDS];
   logic [WORD_W-1:0] pud_q;
   logic [WORD_W-1:0] pudclk_q [PIN_WORDS];

   gpb_result_type expected_results [$];
   int errors;
   int n_checked;
   int n_flagged;

   function automatic void decode_offset(input logic [7:0] off, output gpb_target_type tgt,
                                         output int idx);
      int d;
      tgt = TGT_NONE;
      idx = 0;
      if (off[1:0] != 2'b00) return;
      if (off <= OFF_FSEL_LAST) begin
         tgt = TGT_FSEL;
         idx = int'(off >> 2);
      end else if (off == OFF_SET0 || off == OFF_SET1) begin
         tgt = TGT_SET;
         idx = int'(off == OFF_SET1);
      end else if (off == OFF_CLR0 || off == OFF_CLR1) begin
         tgt = TGT_CLR;
         idx = int'(off == OFF_CLR1);
      end else if (off == OFF_LEV0 || off == OFF_LEV0 + WORD_STEP) begin
         tgt = TGT_LEV;
         idx = int'(off != OFF_LEV0);
      end else if (off == OFF_EDS0 || off == OFF_EDS0 + WORD_STEP) begin
         tgt = TGT_EDS;
         idx = int'(off != OFF_EDS0);
      end else if (off >= OFF_DET0 && off <= OFF_DET_LAST) begin
         d = int'(off - OFF_DET0);
         if (d % DET_STRIDE == 0 || d % DET_STRIDE == 4) begin
            tgt = TGT_DET;
            idx = (d / DET_STRIDE * 2 + (d % DET_STRIDE) / 4) % DET_WORDS;
         end
      end else if (off == OFF_PUD) begin
         tgt = TGT_PUD;
      end else if (off == OFF_PUD + WORD_STEP || off == OFF_PUD + 2 * WORD_STEP) begin
         tgt = TGT_PUDCLK;
         idx = int'(off != OFF_PUD + WORD_STEP);
      end
   endfunction

   function automatic logic [FSEL_W-1:0] pin_function(input int p);
      if (p >= FSEL_PINS) return FSEL_INPUT;
      return FSEL_W'(fsel_q[p / FSEL_PER_WORD] >> (FSEL_W * (p % FSEL_PER_WORD)));
   endfunction

   // set wins over clear, only on output pins
   function automatic void drive_pending_pins();
      for (int p = 0; p < NUM_PINS && p < PIN_BITS; p++) begin
         if (pin_function(p) == FSEL_OUTPUT) begin
            if (set_q[p / WORD_W][p % WORD_W]) begin
               drive_q[p / WORD_W][p % WORD_W] = 1'b1;
               set_q[p / WORD_W][p % WORD_W]   = 1'b0;
            end else if (clr_q[p / WORD_W][p % WORD_W]) begin
               drive_q[p / WORD_W][p % WORD_W] = 1'b0;
               clr_q[p / WORD_W][p % WORD_W]   = 1'b0;
            end
         end
      end
   endfunction

   function automatic gpb_result_type gpio_access(input gpb_mode_type mode,
                                                  input logic [7:0] off,
                                                  input logic [WORD_W-1:0] data,
                                                  input logic [5:0] pin, input logic lvl);
      gpb_result_type r;
      gpb_target_type tgt;
      int idx;
      r = '0;
      decode_offset(off, tgt, idx);
      case (mode)
         MODE_READ: begin
            case (tgt)
               TGT_FSEL:   r.read_data = fsel_q[idx];
               TGT_LEV:    r.read_data = level_q[idx];
               TGT_EDS:    r.read_data = status_q[idx];
               TGT_DET:    r.read_data = detect_q[idx];
               TGT_PUD:    r.read_data = pud_q;
               TGT_PUDCLK: r.read_data = pudclk_q[idx];
               default:    r.bad_offset = 1'b1;
            endcase
         end
         MODE_WRITE: begin
            case (tgt)
               TGT_FSEL:   fsel_q[idx] = data;
               TGT_SET:    set_q[idx] = data;
               TGT_CLR:    clr_q[idx] = data;
               TGT_EDS:    status_q[idx] = data;
               TGT_DET:    detect_q[idx] = data;
               TGT_PUD:    pud_q = data;
               TGT_PUDCLK: pudclk_q[idx] = data;
               default:    r.bad_offset = 1'b1;
            endcase
            if (!r.bad_offset) drive_pending_pins();
         end
         MODE_EVENT: begin
            if (pin < NUM_PINS && pin_function(pin) == FSEL_INPUT)
               level_q[pin / WORD_W][pin % WORD_W] = lvl;
         end
         default: ;
      endcase
      r.out_low  = drive_q[0];
      r.out_high = drive_q[1][OUT_HIGH_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                              input logic [WORD_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      gpb_result_type exp_r;
      if (reset) begin
         foreach (fsel_q[i]) fsel_q[i] = '0;
         foreach (detect_q[i]) detect_q[i] = '0;
         for (int i = 0; i < PIN_WORDS; i++) begin
            set_q[i]    = '0;
            clr_q[i]    = '0;
            drive_q[i]  = '0;
            level_q[i]  = '0;
            status_q[i] = '0;
            pudclk_q[i] = '0;
         end
         pud_q = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result item with nothing expected");
               errors++;
            end else begin
               exp_r = expected_results.pop_front();
               check_field("read_data", exp_r.read_data, rsp_read_data);
               check_field("bad_offset", WORD_W'(exp_r.bad_offset), WORD_W'(rsp_bad_offset));
               check_field("out_pins_low", exp_r.out_low, rsp_out_pins_low);
               check_field("out_pins_high", WORD_W'(exp_r.out_high),
                           WORD_W'(rsp_out_pins_high));
               n_checked++;
               if (rsp_bad_offset) n_flagged++;
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(gpio_access(gpb_mode_type'(req_mode), req_offset,
                                                   req_write_data, req_pin, req_level));
      end
      fail_count <= errors;
      waiting    <= expected_results.size();
      checked    <= n_checked;
      flagged    <= n_flagged;
   end

endmodule

@@ verif/tb.sv @@
// tb: stimulus and verdict for the gpio pin register block
// directed register accesses and pin events, then a random mix with idling on both sides
// depends on gpb_pkg, gpio_pin_register_block and gpb_checker
`timescale 1ns / 1ps

module tb;
   import gpb_pkg::*;

   localparam logic [WORD_W-1:0] ALL_OUTPUT_FSEL = WORD_W'({FSEL_PER_WORD{FSEL_OUTPUT}});
   localparam int RANDOM_ITEMS = 1050;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = MODE_READ;
   logic [7:0] req_offset = '0;
   logic [WORD_W-1:0] req_write_data = '0;
   logic [5:0] req_pin = '0;
   logic req_level = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [WORD_W-1:0] rsp_read_data;
   logic rsp_bad_offset;
   logic [WORD_W-1:0] rsp_out_pins_low;
   logic [OUT_HIGH_W-1:0] rsp_out_pins_high;

   int fail_count;
   int waiting;
   int checked;
   int flagged;
   int items = 0;
   logic quiet;

   always #2 clock = ~clock;

   // long stretch with no idling on either side
   assign quiet = (items >= 450 && items < 650);

   gpio_pin_register_block dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_offset        (req_offset),
      .req_write_data    (req_write_data),
      .req_pin           (req_pin),
      .req_level         (req_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_bad_offset    (rsp_bad_offset),
      .rsp_out_pins_low  (rsp_out_pins_low),
      .rsp_out_pins_high (rsp_out_pins_high)
   );

   gpb_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_offset        (req_offset),
      .req_write_data    (req_write_data),
      .req_pin           (req_pin),
      .req_level         (req_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_bad_offset    (rsp_bad_offset),
      .rsp_out_pins_low  (rsp_out_pins_low),
      .rsp_out_pins_high (rsp_out_pins_high),
      .fail_count        (fail_count),
      .waiting           (waiting),
      .checked           (checked),
      .flagged           (flagged)
   );

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 15);
      end
   end

   task automatic send(input gpb_mode_type mode, input logic [7:0] off,
                       input logic [WORD_W-1:0] data, input logic [5:0] pin, input logic lvl);
      while (!quiet && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_offset     <= off;
      req_write_data <= data;
      req_pin        <= pin;
      req_level      <= lvl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items++;
   endtask

   // mostly input and output pins so that set, clear and level events all matter
   function automatic logic [WORD_W-1:0] random_fsel_word();
      logic [WORD_W-1:0] w;
      int r;
      w = $urandom;
      for (int f = 0; f < FSEL_PER_WORD; f++) begin
         r = $urandom_range(5);
         if (r < 2) w[FSEL_W*f +: FSEL_W] = FSEL_INPUT;
         else if (r < 4) w[FSEL_W*f +: FSEL_W] = FSEL_OUTPUT;
      end
      return w;
   endfunction

   function automatic logic [7:0] random_register(input bit for_write);
      case ($urandom_range(9))
         0, 1, 2: return 8'(WORD_STEP * $urandom_range(FSEL_WORDS - 1));
         3, 4: begin
            if (for_write) return $urandom_range(1) ? OFF_SET1 : OFF_SET0;
            return 8'(OFF_LEV0 + WORD_STEP * $urandom_range(1));
         end
         5: begin
            if (for_write) return $urandom_range(1) ? OFF_CLR1 : OFF_CLR0;
            return 8'(OFF_LEV0 + WORD_STEP * $urandom_range(1));
         end
         6: return 8'(OFF_EDS0 + WORD_STEP * $urandom_range(1));
         7, 8: return 8'(OFF_DET0 + DET_STRIDE * $urandom_range(DET_GROUPS - 1)
                         + WORD_STEP * $urandom_range(1));
         default: return 8'(OFF_PUD + WORD_STEP * $urandom_range(2));
      endcase
   endfunction

   initial begin
      #200000;
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      logic [7:0] off;
      int r;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: outputs on pins 0-9, 30-39, 50-53, then set and clear passes
      send(MODE_WRITE, 8'h00, ALL_OUTPUT_FSEL, '0, 1'b0);
      send(MODE_WRITE, 8'(3 * WORD_STEP), ALL_OUTPUT_FSEL, '0, 1'b0);
      send(MODE_WRITE, OFF_FSEL_LAST, ALL_OUTPUT_FSEL, '0, 1'b0);
      send(MODE_WRITE, OFF_SET0, '1, '0, 1'b0);
      send(MODE_WRITE, OFF_CLR0, '1, '0, 1'b0);
      send(MODE_WRITE, OFF_SET1, '1, '0, 1'b0);
      send(MODE_WRITE, OFF_CLR1, '1, '0, 1'b0);
      send(MODE_WRITE, OFF_SET1, '1, '0, 1'b0);
      send(MODE_READ, OFF_FSEL_LAST, '0, '0, 1'b0);
      // write-only, read-only, unaligned, reserved and unknown offsets
      send(MODE_READ, OFF_SET0, '1, '1, 1'b1);
      send(MODE_WRITE, OFF_LEV0, '1, '0, 1'b0);
      send(MODE_READ, 8'h01, '0, '0, 1'b0);
      send(MODE_READ, OFF_FSEL_LAST + WORD_STEP, '0, '0, 1'b0);
      send(MODE_READ, 8'(OFF_DET0 + 2 * WORD_STEP), '0, '0, 1'b0);
      send(MODE_WRITE, 8'hff, '1, '0, 1'b0);
      // level events on an output pin, a pin out of range and two inputs
      send(MODE_EVENT, '0, '0, 6'd0, 1'b1);
      send(MODE_EVENT, '0, '0, 6'd63, 1'b1);
      send(MODE_EVENT, '0, '0, 6'd40, 1'b1);
      send(MODE_EVENT, '0, '0, 6'd10, 1'b1);
      send(MODE_READ, OFF_LEV0 + WORD_STEP, '0, '0, 1'b0);
      send(MODE_NONE, '1, '1, '1, 1'b1);
      send(MODE_WRITE, OFF_DET_LAST, 32'ha5a5a5a5, '0, 1'b0);
      send(MODE_READ, OFF_DET_LAST, '0, '0, 1'b0);
      send(MODE_WRITE, 8'(OFF_PUD + 2 * WORD_STEP), '1, '0, 1'b0);
      send(MODE_READ, 8'(OFF_PUD + 2 * WORD_STEP), '0, '0, 1'b0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = $urandom_range(99);
         if (r < 40) begin
            off = random_register(1'b1);
            send(MODE_WRITE, off, (off <= OFF_FSEL_LAST) ? random_fsel_word() : $urandom,
                 6'($urandom), 1'($urandom));
         end else if (r < 62) begin
            send(MODE_READ, random_register(1'b0), $urandom, 6'($urandom), 1'($urandom));
         end else if (r < 87) begin
            send(MODE_EVENT, 8'($urandom), $urandom, 6'($urandom_range(63)),
                 1'($urandom));
         end else begin
            send(gpb_mode_type'($urandom_range(3)), 8'($urandom_range(255)), $urandom,
                 6'($urandom), 1'($urandom));
         end
      end
      req_valid <= 1'b0;

      repeat (2) @(posedge clock);
      while (waiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d reads, writes, level events and unused-mode items", items);
      $display("%0d results checked, %0d of them flagged as bad offsets", checked, flagged);
      if (fail_count == 0 && waiting == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
